// File: hdl/cpmt_pkg.sv
package cpmt_pkg;

  // Problem size and field widths
  localparam int MAX_VERTICES = 8;
  localparam int WEIGHT_BITS  = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_W       = 2 * IDX_W;
  localparam int RAM_DEPTH    = 1 << ADDR_W;
  localparam int COST_W       = 20;
  localparam int SUM_W        = ((COST_W > WEIGHT_BITS) ? COST_W : WEIGHT_BITS) + 2;
  localparam int OUT_IDX_W    = 3;
  localparam int VCOUNT_W     = 4;
  localparam int VCOUNT_RESET = 8;
  localparam int MIN_VERTICES = 3;
  localparam longint unsigned COST_MAX = (64'd1 << COST_W) - 64'd1;

  // Stream payload widths
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 32;

  // Input kinds carried on s_tuser
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_SOLVE = 1'b1;

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [COST_W-1:0]      cost_t;
  typedef logic [WEIGHT_BITS-1:0] weight_t;
  typedef logic [SUM_W-1:0]       sum_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT_RD,
    ST_INIT_WR,
    ST_K_RD,
    ST_K_ACC,
    ST_WRITE
  } state_t;

  // Clamp a sum to the largest cost
  function automatic cost_t sat_cost(input sum_t v);
    if (v > sum_t'(COST_MAX)) begin
      sat_cost = cost_t'(COST_MAX);
    end else begin
      sat_cost = cost_t'(v);
    end
  endfunction

endpackage

// File: hdl/cpmt_ram.sv
module cpmt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read two with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// File: hdl/convex_polygon_min_triangulation.sv
// Minimum-weight triangulation of a convex polygon over a loaded weight matrix.
// Input stream s_*: s_tuser selects the request kind. A load request writes
// weight (row, col) and gives no result. A solve request runs the
// interval dynamic program for vertex_count vertices (clamped to 3..8) and
// emits one result per interval of length two or more, by length and then by
// first vertex; the whole polygon comes last with m_tlast high.
// Config channel cfg_*: writes vertex_count (reset 8); write it only when idle.
// Schedule: one shared adder/compare unit walks the split points; each split
// reads the cost memory (ST_K_RD), then accumulates (ST_K_ACC). A solve first
// seeds each edge (b,b+1) (ST_INIT_RD, ST_INIT_WR), then walks each interval (b,e)
// and ends it in ST_WRITE. The dual-read cost memory gives both costs in one read.
// s_tready is high only while no solve is running.
// Results sit in one output register; when the receiver stalls the solve holds
// at the next interval, and new requests are taken once the last result is in
// the register. Reset (rst, synchronous) returns to idle and drops any pending
// result; the weight matrix keeps its contents.
module convex_polygon_min_triangulation (
  input  logic                           clk,
  input  logic                           rst,
  // row [2:0], col [5:3], weight_value [21:6], zero pad [23:22]
  input  logic [cpmt_pkg::S_TDATA_W-1:0] s_tdata,
  // mode [0]
  input  logic                           s_tuser,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // interval_begin [2:0], interval_end [5:3], min_cost [25:6],
  // split_vertex [28:26], zero pad [31:29]
  output logic [cpmt_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [cpmt_pkg::VCOUNT_W-1:0]  cfg_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready
);

  cpmt_pkg::state_t st, st_next;
  cpmt_pkg::cnt_t   n, n_next;
  cpmt_pkg::idx_t   b, b_next;
  cpmt_pkg::idx_t   e, e_next;
  cpmt_pkg::idx_t   k, k_next;
  cpmt_pkg::idx_t   len, len_next;
  cpmt_pkg::cost_t  best, best_next;
  cpmt_pkg::idx_t   bestk, bestk_next;

  logic [cpmt_pkg::VCOUNT_W-1:0] vertex_count;

  logic                           out_valid;
  logic [cpmt_pkg::OUT_IDX_W-1:0] out_begin;
  logic [cpmt_pkg::OUT_IDX_W-1:0] out_end;
  cpmt_pkg::cost_t                out_cost;
  logic [cpmt_pkg::OUT_IDX_W-1:0] out_split;
  logic                           out_last;

  logic              in_accept;
  logic              emit_ok;
  logic              out_load;
  logic              more;
  logic              load_ok;
  cpmt_pkg::addr_t   w_wr_addr;
  cpmt_pkg::addr_t   w_rd_addr;
  cpmt_pkg::weight_t w_rd;
  logic              c_we;
  cpmt_pkg::addr_t   c_wr_addr;
  cpmt_pkg::cost_t   c_wr_data;
  cpmt_pkg::addr_t   c_rd_addr_a;
  cpmt_pkg::addr_t   c_rd_addr_b;
  cpmt_pkg::cost_t   c_rd_a;
  cpmt_pkg::cost_t   c_rd_b;
  cpmt_pkg::sum_t    sum;
  cpmt_pkg::cost_t   sum_sat;
  logic              k_first;
  cpmt_pkg::cnt_t    n_clamp;

  // Handshake and shared unit
  assign s_tready  = (st == cpmt_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid && s_tready;
  assign emit_ok   = !out_valid || m_tready;
  assign out_load  = (st == cpmt_pkg::ST_WRITE) && emit_ok;
  assign more      = ((cpmt_pkg::cnt_t'(e) + cpmt_pkg::cnt_t'(1)) < n) ||
                     ((cpmt_pkg::cnt_t'(len) + cpmt_pkg::cnt_t'(1)) < n);
  assign sum       = cpmt_pkg::sum_t'(c_rd_a) + cpmt_pkg::sum_t'(c_rd_b) +
                     cpmt_pkg::sum_t'(w_rd);
  assign sum_sat   = cpmt_pkg::sat_cost(sum);
  assign k_first   = (k == (b + cpmt_pkg::idx_t'(1)));

  // Clamp the vertex count for a solve
  always_comb begin
    if (vertex_count < cpmt_pkg::VCOUNT_W'(cpmt_pkg::MIN_VERTICES)) begin
      n_clamp = cpmt_pkg::cnt_t'(cpmt_pkg::MIN_VERTICES);
    end else if (int'(vertex_count) > cpmt_pkg::MAX_VERTICES) begin
      n_clamp = cpmt_pkg::cnt_t'(cpmt_pkg::MAX_VERTICES);
    end else begin
      n_clamp = cpmt_pkg::cnt_t'(vertex_count);
    end
  end

  // Next state
  always_comb begin
    st_next = st;
    case (st)
      cpmt_pkg::ST_IDLE: begin
        if (in_accept && (s_tuser == cpmt_pkg::MODE_SOLVE)) begin
          st_next = cpmt_pkg::ST_INIT_RD;
        end
      end
      cpmt_pkg::ST_INIT_RD: begin
        st_next = cpmt_pkg::ST_INIT_WR;
      end
      cpmt_pkg::ST_INIT_WR: begin
        if ((cpmt_pkg::cnt_t'(b) + cpmt_pkg::cnt_t'(2)) == n) begin
          st_next = cpmt_pkg::ST_K_RD;
        end else begin
          st_next = cpmt_pkg::ST_INIT_RD;
        end
      end
      cpmt_pkg::ST_K_RD: begin
        st_next = cpmt_pkg::ST_K_ACC;
      end
      cpmt_pkg::ST_K_ACC: begin
        if ((k + cpmt_pkg::idx_t'(1)) == e) begin
          st_next = cpmt_pkg::ST_WRITE;
        end else begin
          st_next = cpmt_pkg::ST_K_RD;
        end
      end
      cpmt_pkg::ST_WRITE: begin
        if (emit_ok) begin
          st_next = more ? cpmt_pkg::ST_K_RD : cpmt_pkg::ST_IDLE;
        end
      end
      default: begin
        st_next = cpmt_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs: counters, accumulator and memory control
  always_comb begin
    n_next      = n;
    b_next      = b;
    e_next      = e;
    k_next      = k;
    len_next    = len;
    best_next   = best;
    bestk_next  = bestk;
    c_we        = 1'b0;
    c_wr_addr   = {b, e};
    c_wr_data   = best;
    w_rd_addr   = {b, e};
    c_rd_addr_a = {b, k};
    c_rd_addr_b = {k, e};
    case (st)
      cpmt_pkg::ST_IDLE: begin
        if (in_accept && (s_tuser == cpmt_pkg::MODE_SOLVE)) begin
          n_next = n_clamp;
          b_next = '0;
        end
      end
      cpmt_pkg::ST_INIT_RD: begin
        w_rd_addr = {b, b + cpmt_pkg::idx_t'(1)};
      end
      cpmt_pkg::ST_INIT_WR: begin
        c_we      = 1'b1;
        c_wr_addr = {b, b + cpmt_pkg::idx_t'(1)};
        c_wr_data = cpmt_pkg::sat_cost(cpmt_pkg::sum_t'(w_rd));
        if ((cpmt_pkg::cnt_t'(b) + cpmt_pkg::cnt_t'(2)) == n) begin
          len_next = cpmt_pkg::idx_t'(2);
          b_next   = '0;
          e_next   = cpmt_pkg::idx_t'(2);
          k_next   = cpmt_pkg::idx_t'(1);
        end else begin
          b_next = b + cpmt_pkg::idx_t'(1);
        end
      end
      cpmt_pkg::ST_K_ACC: begin
        if (k_first || (sum_sat < best)) begin
          best_next  = sum_sat;
          bestk_next = k;
        end
        k_next = k + cpmt_pkg::idx_t'(1);
      end
      cpmt_pkg::ST_WRITE: begin
        if (emit_ok) begin
          c_we = 1'b1;
          if ((cpmt_pkg::cnt_t'(e) + cpmt_pkg::cnt_t'(1)) < n) begin
            b_next = b + cpmt_pkg::idx_t'(1);
            e_next = e + cpmt_pkg::idx_t'(1);
            k_next = b + cpmt_pkg::idx_t'(2);
          end else begin
            len_next = len + cpmt_pkg::idx_t'(1);
            b_next   = '0;
            e_next   = len + cpmt_pkg::idx_t'(1);
            k_next   = cpmt_pkg::idx_t'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Weight load decode
  assign load_ok   = in_accept && (s_tuser == cpmt_pkg::MODE_LOAD) &&
                     (int'(s_tdata[2:0]) < cpmt_pkg::MAX_VERTICES) &&
                     (int'(s_tdata[5:3]) < cpmt_pkg::MAX_VERTICES);
  assign w_wr_addr = {cpmt_pkg::idx_t'(s_tdata[2:0]), cpmt_pkg::idx_t'(s_tdata[5:3])};

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= cpmt_pkg::ST_IDLE;
      vertex_count <= cpmt_pkg::VCOUNT_W'(cpmt_pkg::VCOUNT_RESET);
      out_valid    <= 1'b0;
    end else begin
      st <= st_next;
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    n     <= n_next;
    b     <= b_next;
    e     <= e_next;
    k     <= k_next;
    len   <= len_next;
    best  <= best_next;
    bestk <= bestk_next;
    if (out_load) begin
      out_begin <= cpmt_pkg::OUT_IDX_W'(b);
      out_end   <= cpmt_pkg::OUT_IDX_W'(e);
      out_cost  <= best;
      out_split <= cpmt_pkg::OUT_IDX_W'(bestk);
      out_last  <= (b == '0) && ((cpmt_pkg::cnt_t'(e) + cpmt_pkg::cnt_t'(1)) == n);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {3'b000, out_split, out_cost, out_end, out_begin};

  cpmt_ram #(
    .WIDTH(cpmt_pkg::WEIGHT_BITS),
    .DEPTH(cpmt_pkg::RAM_DEPTH)
  ) u_weight_ram (
    .clk      (clk),
    .we       (load_ok),
    .wr_addr  (w_wr_addr),
    .wr_data  (cpmt_pkg::WEIGHT_BITS'(s_tdata[21:6])),
    .rd_addr_a(w_rd_addr),
    .rd_data_a(w_rd),
    .rd_addr_b(w_rd_addr),
    .rd_data_b()
  );

  cpmt_ram #(
    .WIDTH(cpmt_pkg::COST_W),
    .DEPTH(cpmt_pkg::RAM_DEPTH)
  ) u_cost_ram (
    .clk      (clk),
    .we       (c_we),
    .wr_addr  (c_wr_addr),
    .wr_data  (c_wr_data),
    .rd_addr_a(c_rd_addr_a),
    .rd_data_a(c_rd_a),
    .rd_addr_b(c_rd_addr_b),
    .rd_data_b(c_rd_b)
  );

`ifndef SYNTHESIS
  a_split_inside: assert property (@(posedge clk) disable iff (rst)
    (st == cpmt_pkg::ST_K_ACC) |-> ((k > b) && (k < e)))
    else $error("split point outside its interval");

  a_end_in_range: assert property (@(posedge clk) disable iff (rst)
    ((st == cpmt_pkg::ST_K_RD) || (st == cpmt_pkg::ST_WRITE)) |->
      (cpmt_pkg::cnt_t'(e) < n))
    else $error("interval end beyond vertex count");

  a_last_whole: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[2:0] == 3'd0))
    else $error("last result is not the whole polygon");

  a_solve_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == cpmt_pkg::MODE_SOLVE)) |=>
      (st == cpmt_pkg::ST_INIT_RD))
    else $error("solve request did not start seeding");

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid)
    else $error("emitted result not presented");
`endif

endmodule
